>>> hdl/sfvu_pkg.sv
// ---------------------------------------------------------------------------
// Stereo frame VU meter package
// Shared widths, constants and handshake structs for the meter core.
// ---------------------------------------------------------------------------
package sfvu_pkg;

	localparam int MAX_FRAME_PAIRS = 4096;
	localparam int LEVEL_BITS      = 16;

	localparam int SAMPLE_W = 16;
	localparam int FIELD_W  = 16;
	localparam int SQUARE_W = 2 * SAMPLE_W;
	localparam int SUM_W    = 42;
	localparam int CNT_W    = $clog2(MAX_FRAME_PAIRS + 1);
	localparam int DIVC_W   = $clog2(SUM_W);

	// Mean square is limited to full scale squared, 2^30, so it needs 31 bits.
	localparam int MEAN_W   = 31;
	localparam int MSB_W    = 5;
	localparam int FRAC_W   = 16;
	localparam int ROUND_W  = $clog2(FRAC_W);
	localparam int LOG_W    = MSB_W + FRAC_W;
	localparam int SQP_W    = 2 * MEAN_W;
	localparam int PROD_W   = 2 * LOG_W;
	localparam int RND_SH   = 40 - LEVEL_BITS;
	localparam int DROP_W   = PROD_W + 1 - RND_SH;

	localparam logic [LOG_W-1:0]  NEG_TOP   = LOG_W'(30 * (1 << FRAC_W));
	localparam logic [LOG_W-1:0]  LOG_SCALE = LOG_W'(1683482);
	localparam logic [MEAN_W-1:0] FULL_SQ   = MEAN_W'(1 << 30);

	localparam int S_TDATA_W = 2 * SAMPLE_W;
	localparam int M_TDATA_W = 40;

	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [FIELD_W-1:0] level_t;

	// Frame close request from the accumulator to both lanes.
	typedef struct packed {
		logic   start;
		sum_t   left_sum;
		sum_t   right_sum;
		count_t count;
	} frame_t;

	// Lane status toward the merge stage.
	typedef struct packed {
		logic   idle;
		logic   done;
		level_t level;
	} lane_stat_t;

endpackage

>>> hdl/sfvu_accum.sv
// ---------------------------------------------------------------------------
// Square accumulator
// Sums squared left and right samples and counts pairs over one frame.
// ---------------------------------------------------------------------------
module sfvu_accum
	import sfvu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [S_TDATA_W-1:0] pair,
	input  logic                 last,
	output frame_t               frame
);

	sum_t   left_sum_q;
	sum_t   right_sum_q;
	count_t count_q;

	logic signed [SAMPLE_W-1:0] left_s;
	logic signed [SAMPLE_W-1:0] right_s;
	logic [SAMPLE_W-1:0]        left_mag;
	logic [SAMPLE_W-1:0]        right_mag;
	logic [SQUARE_W-1:0]        left_sq;
	logic [SQUARE_W-1:0]        right_sq;
	logic [SUM_W:0]             left_add;
	logic [SUM_W:0]             right_add;
	logic                       room;
	sum_t                       left_next;
	sum_t                       right_next;
	count_t                     count_next;

	always_comb begin
		left_s   = pair[SAMPLE_W-1:0];
		right_s  = pair[2*SAMPLE_W-1:SAMPLE_W];
		// Negating the most negative sample wraps to 0x8000, which is its magnitude.
		left_mag  = left_s[SAMPLE_W-1] ? SAMPLE_W'(-left_s) : SAMPLE_W'(left_s);
		right_mag = right_s[SAMPLE_W-1] ? SAMPLE_W'(-right_s) : SAMPLE_W'(right_s);
		left_sq   = SQUARE_W'(left_mag) * SQUARE_W'(left_mag);
		right_sq  = SQUARE_W'(right_mag) * SQUARE_W'(right_mag);
		left_add  = {1'b0, left_sum_q} + (SUM_W+1)'(left_sq);
		right_add = {1'b0, right_sum_q} + (SUM_W+1)'(right_sq);
		room      = count_q < CNT_W'(MAX_FRAME_PAIRS);
		if (room) begin
			left_next  = left_add[SUM_W] ? {SUM_W{1'b1}} : left_add[SUM_W-1:0];
			right_next = right_add[SUM_W] ? {SUM_W{1'b1}} : right_add[SUM_W-1:0];
			count_next = count_q + 1'b1;
		end else begin
			left_next  = left_sum_q;
			right_next = right_sum_q;
			count_next = count_q;
		end
		frame.start     = accept & last;
		frame.left_sum  = left_next;
		frame.right_sum = right_next;
		frame.count     = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sum_q  <= '0;
			right_sum_q <= '0;
			count_q     <= '0;
		end else if (accept) begin
			if (last) begin
				left_sum_q  <= '0;
				right_sum_q <= '0;
				count_q     <= '0;
			end else begin
				left_sum_q  <= left_next;
				right_sum_q <= right_next;
				count_q     <= count_next;
			end
		end
	end

endmodule

>>> hdl/sfvu_lane.sv
// ---------------------------------------------------------------------------
// Level lane
// Turns one channel's frame sum into a meter level: serial divide, normalize,
// squaring log2, scale to decibels and map onto the level range.
// ---------------------------------------------------------------------------
module sfvu_lane
	import sfvu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  sum_t       sum,
	input  count_t     count,
	input  logic       ack,
	output lane_stat_t stat
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_SQM  = 3'd3;
	localparam logic [2:0] ST_SQF  = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]        state_q;
	logic [DIVC_W-1:0] div_cnt_q;
	logic [ROUND_W-1:0] round_q;

	sum_t              quo_q;
	count_t            div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [MEAN_W-1:0] m_q;
	logic [MSB_W-1:0]  msb_q;
	logic [FRAC_W-1:0] frac_q;
	logic [SQP_W-1:0]  sq_q;
	logic [PROD_W-1:0] prod_q;
	level_t            level_q;

	logic [CNT_W:0]    shifted;
	logic              ge;
	logic [CNT_W-1:0]  rem_next;
	sum_t              quo_next;
	logic              over;
	logic [MEAN_W-1:0] mean;
	logic [MEAN_W:0]   sq_top;
	logic [LOG_W-1:0]  neg;
	logic [PROD_W:0]   rounded;
	logic [DROP_W-1:0] drop;
	logic [LEVEL_BITS-1:0] lvl;

	always_comb begin
		// One restoring division step per cycle.
		shifted  = {rem_q, quo_q[SUM_W-1]};
		ge       = shifted >= {1'b0, div_q};
		rem_next = ge ? CNT_W'(shifted - {1'b0, div_q}) : CNT_W'(shifted);
		quo_next = {quo_q[SUM_W-2:0], ge};
		over     = (quo_next[SUM_W-1:MEAN_W] != '0) ||
			(quo_next[MEAN_W-1] && (quo_next[MEAN_W-2:0] != '0));
		mean     = over ? FULL_SQ : quo_next[MEAN_W-1:0];

		sq_top   = sq_q[SQP_W-1:30];

		neg      = NEG_TOP - {msb_q, frac_q};
		rounded  = {1'b0, prod_q} + (PROD_W+1)'(1 << (RND_SH - 1));
		drop     = rounded[PROD_W:RND_SH];
		if (drop[DROP_W-1:LEVEL_BITS] != '0) begin
			lvl = '0;
		end else if (drop == '0) begin
			lvl = {LEVEL_BITS{1'b1}};
		end else begin
			lvl = LEVEL_BITS'(~drop[LEVEL_BITS-1:0] + 1'b1);
		end

		stat.idle  = state_q == ST_IDLE;
		stat.done  = state_q == ST_DONE;
		stat.level = level_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			round_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					div_cnt_q <= '0;
					if (start) begin
						state_q <= (count == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIVC_W'(SUM_W - 1)) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					round_q <= '0;
					if (m_q == '0) begin
						state_q <= ST_DONE;
					end else if (m_q[MEAN_W-1]) begin
						state_q <= ST_SQM;
					end
				end
				ST_SQM: begin
					state_q <= ST_SQF;
				end
				ST_SQF: begin
					round_q <= round_q + 1'b1;
					state_q <= (round_q == {ROUND_W{1'b1}}) ? ST_MUL : ST_SQM;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q   <= sum;
				div_q   <= count;
				rem_q   <= '0;
				level_q <= '0;
			end
			ST_DIV: begin
				quo_q <= quo_next;
				rem_q <= rem_next;
				m_q   <= mean;
				msb_q <= MSB_W'(30);
			end
			ST_NORM: begin
				frac_q <= '0;
				if (!m_q[MEAN_W-1]) begin
					m_q   <= {m_q[MEAN_W-2:0], 1'b0};
					msb_q <= msb_q - 1'b1;
				end
			end
			ST_SQM: begin
				sq_q <= SQP_W'(m_q) * SQP_W'(m_q);
			end
			ST_SQF: begin
				// A square of 2.0 or more yields a one bit and is halved.
				if (sq_top[MEAN_W]) begin
					m_q    <= sq_top[MEAN_W:1];
					frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
				end else begin
					m_q    <= sq_top[MEAN_W-1:0];
					frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(neg) * PROD_W'(LOG_SCALE);
			end
			ST_FIN: begin
				level_q <= FIELD_W'(lvl);
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/sfvu_merge.sv
// ---------------------------------------------------------------------------
// Result merge
// Joins both lane levels, flags changes against the previous frame and
// holds the result word until the receiver takes it.
// ---------------------------------------------------------------------------
module sfvu_merge
	import sfvu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_stat_t           left_stat,
	input  lane_stat_t           right_stat,
	output logic                 ack,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic                 valid_q;
	logic [M_TDATA_W-1:0] data_q;
	level_t               prev_left_q;
	level_t               prev_right_q;

	assign ack      = left_stat.done && right_stat.done && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			prev_left_q  <= '0;
			prev_right_q <= '0;
		end else begin
			if (ack) begin
				valid_q      <= 1'b1;
				prev_left_q  <= left_stat.level;
				prev_right_q <= right_stat.level;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			data_q <= M_TDATA_W'({right_stat.level != prev_right_q,
				left_stat.level != prev_left_q,
				right_stat.level, left_stat.level});
		end
	end

endmodule

>>> hdl/stereo_frame_vu_meter_core.sv
// ---------------------------------------------------------------------------
// Stereo frame VU meter core
// Per-frame RMS level meter in decibels for a stereo sample stream.
// ---------------------------------------------------------------------------
// Usage:
// The slave channel takes one stereo sample pair per word; s_tlast marks the
// last pair of a frame. Pairs are accumulated at one word per cycle while
// s_tready is high. On the last pair, two identical lanes (left and right)
// compute the level in parallel: a serial divide for the mean square,
// normalization, 16 squaring rounds for log2, then a multiply and a mapping
// step. The result word then appears on the master channel; the lane of a
// silent channel skips the squaring, multiply and mapping steps.
// Pairs of the next frame keep flowing in meanwhile; only a last pair that
// arrives while the lanes still work on the previous frame waits, so frames
// shorter than the lanes' processing time slow the input down.
// If the receiver stalls, the result word is held in the output register and
// the lanes keep their finished levels until it is taken.
// Reset clears the sums, the pair count, the previous levels and the output
// valid flag.
// ---------------------------------------------------------------------------
module stereo_frame_vu_meter_core
	import sfvu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [15:0] left_sample, [31:16] right_sample
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [15:0] left_level, [31:16] right_level, [32] left_changed,
	// [33] right_changed, [39:34] zero
	output logic [M_TDATA_W-1:0] m_tdata
);

	frame_t     frame;
	lane_stat_t left_stat;
	lane_stat_t right_stat;
	logic       ack;
	logic       lanes_busy;
	logic       accept;

	// Only a frame-closing word has to wait for the lanes.
	assign lanes_busy = !(left_stat.idle && right_stat.idle);
	assign s_tready   = !(lanes_busy && s_tlast);
	assign accept     = s_tvalid && s_tready;

	sfvu_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pair   (s_tdata),
		.last   (s_tlast),
		.frame  (frame)
	);

	sfvu_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (frame.start),
		.sum    (frame.left_sum),
		.count  (frame.count),
		.ack    (ack),
		.stat   (left_stat)
	);

	sfvu_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (frame.start),
		.sum    (frame.right_sum),
		.count  (frame.count),
		.ack    (ack),
		.stat   (right_stat)
	);

	sfvu_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.left_stat  (left_stat),
		.right_stat (right_stat),
		.ack        (ack),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
